/* rtl/psslt_pkg.sv */
// shared widths, result codes and controller/datapath signal groups for the loss tracker
`timescale 1ns / 1ps

package psslt_pkg;

    localparam int MAC_W  = 48;
    localparam int SEQ_W  = 32;
    localparam int LEN_W  = 8;
    localparam int CNT_W  = 32;
    localparam int STAT_W = 2;
    localparam int SLOT_W = 2;

    // input transfer: src_mac, seq_num, frame_len from the lowest bit up
    localparam int IN_W  = MAC_W + SEQ_W + LEN_W;
    // result transfer: status, slot, rx_count, missed_total, zero fill to whole bytes
    localparam int RES_W = STAT_W + SLOT_W + CNT_W + CNT_W;
    localparam int OUT_W = ((RES_W + 7) / 8) * 8;
    localparam int PAD_W = OUT_W - RES_W;

    localparam logic [LEN_W-1:0] MIN_LEN_RESET = 8'd28;

    typedef enum logic [STAT_W-1:0] {
        ST_TRACKED = 2'd0,
        ST_SHORT   = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic start;
        logic scan;
        logic take_hit;
        logic take_free;
        logic fetch;
        logic gap;
        logic upd;
        logic res_short;
        logic res_full;
        logic load_out;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic short_frame;
        logic hit;
        logic last;
        logic free_found;
        logic out_free;
    } t_sts;

endpackage

/* rtl/psslt_ctrl.sv */
// sequencing state machine for the loss tracker
`timescale 1ns / 1ps

module psslt_ctrl import psslt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_vld,
    output logic o_in_rdy,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_FETCH,
        S_GAP,
        S_UPD,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_rdy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_vld && r_in_rdy) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.short_frame) begin
                    o_cmd.res_short = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit) begin
                    o_cmd.take_hit = 1'b1;
                    n_state        = S_FETCH;
                end else if (i_sts.last) begin
                    if (i_sts.free_found) begin
                        o_cmd.take_free = 1'b1;
                        n_state         = S_FETCH;
                    end else begin
                        o_cmd.res_full = 1'b1;
                        n_state        = S_DONE;
                    end
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_GAP;
            end
            S_GAP: begin
                o_cmd.gap = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_in_rdy <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_in_rdy <= (n_state == S_IDLE);
        end
    end

    assign o_in_rdy = r_in_rdy;

endmodule

/* rtl/psslt_dp.sv */
// slot table, address scan, counter update and result register for the loss tracker
`timescale 1ns / 1ps

module psslt_dp import psslt_pkg::*; #(
    parameter int SLOTS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata,
    input  logic [IN_W-1:0]  i_item,
    input  logic             i_out_rdy,
    output logic             o_out_vld,
    output logic [OUT_W-1:0] o_out_data
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    // slot table
    logic [MAC_W-1:0] m_addr [SLOTS];
    logic [SEQ_W-1:0] m_seq  [SLOTS];
    logic [CNT_W-1:0] m_cnt  [SLOTS];
    logic [CNT_W-1:0] m_mis  [SLOTS];
    logic [SLOTS-1:0] r_used;

    logic [LEN_W-1:0] r_min;
    logic [MAC_W-1:0] r_mac;
    logic [SEQ_W-1:0] r_seq;
    logic [LEN_W-1:0] r_len;

    logic [IW-1:0]    r_scan_idx;
    logic             r_scan_done;
    logic             r_rd_vld;
    logic [IW-1:0]    r_rd_idx;
    logic [MAC_W-1:0] r_rd_mac;
    logic             r_free_vld;
    logic [IW-1:0]    r_free_idx;

    logic [IW-1:0]    r_slot;
    logic             r_new;
    logic [SEQ_W-1:0] r_q_seq;
    logic [CNT_W-1:0] r_q_cnt;
    logic [CNT_W-1:0] r_q_mis;
    logic             r_jump;
    logic [SEQ_W-1:0] r_gap;

    t_status           r_res_status;
    logic [SLOT_W-1:0] r_res_slot;
    logic [CNT_W-1:0]  r_res_cnt;
    logic [CNT_W-1:0]  r_res_mis;

    logic             r_out_vld;
    logic [OUT_W-1:0] r_out_data;

    logic             rd_free;
    logic [SEQ_W-1:0] last_plus1;
    logic [CNT_W-1:0] n_cnt;
    logic [CNT_W-1:0] n_mis;
    logic [IW+1:0]    slot_ext;

    assign rd_free    = r_rd_vld && !r_used[r_rd_idx];
    assign last_plus1 = r_q_seq + 32'd1;
    assign n_cnt      = r_q_cnt + 32'd1;
    assign n_mis      = r_q_mis + (r_jump ? r_gap : '0);
    // slot field carries the low bits of the index only
    assign slot_ext   = {2'b00, r_slot};

    assign o_sts.short_frame = (r_len < r_min);
    assign o_sts.hit         = r_rd_vld && r_used[r_rd_idx] && (r_rd_mac == r_mac);
    assign o_sts.last        = r_rd_vld && (r_rd_idx == LAST);
    assign o_sts.free_found  = r_free_vld || rd_free;
    assign o_sts.out_free    = !r_out_vld || i_out_rdy;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min       <= MIN_LEN_RESET;
            r_used      <= '0;
            r_scan_idx  <= '0;
            r_scan_done <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_rd_idx    <= '0;
            r_free_vld  <= 1'b0;
            r_free_idx  <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min <= i_cfg_wdata;
            end
            if (i_cmd.start) begin
                r_scan_idx  <= '0;
                r_scan_done <= 1'b0;
                r_rd_vld    <= 1'b0;
                r_free_vld  <= 1'b0;
            end else if (i_cmd.scan) begin
                r_rd_vld <= !r_scan_done;
                r_rd_idx <= r_scan_idx;
                if (!r_scan_done) begin
                    if (r_scan_idx == LAST) begin
                        r_scan_done <= 1'b1;
                    end else begin
                        r_scan_idx <= r_scan_idx + 1'b1;
                    end
                end
                // remember the lowest free slot seen so far
                if (rd_free && !r_free_vld) begin
                    r_free_vld <= 1'b1;
                    r_free_idx <= r_rd_idx;
                end
            end
            if (i_cmd.fetch && r_new) begin
                r_used[r_slot] <= 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_rdy) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload and table
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mac <= i_item[MAC_W-1:0];
            r_seq <= i_item[MAC_W+SEQ_W-1:MAC_W];
            r_len <= i_item[IN_W-1:MAC_W+SEQ_W];
        end
        if (i_cmd.scan && !r_scan_done) begin
            r_rd_mac <= m_addr[r_scan_idx];
        end
        if (i_cmd.take_hit) begin
            r_slot <= r_rd_idx;
            r_new  <= 1'b0;
        end else if (i_cmd.take_free) begin
            r_slot <= r_free_vld ? r_free_idx : r_rd_idx;
            r_new  <= 1'b1;
        end
        if (i_cmd.fetch) begin
            // a freshly claimed slot has never been written
            r_q_seq <= r_new ? '0 : m_seq[r_slot];
            r_q_cnt <= r_new ? '0 : m_cnt[r_slot];
            r_q_mis <= r_new ? '0 : m_mis[r_slot];
            if (r_new) begin
                m_addr[r_slot] <= r_mac;
            end
        end
        if (i_cmd.gap) begin
            r_jump <= (r_q_cnt != '0) && (r_seq > last_plus1);
            r_gap  <= r_seq - last_plus1;
        end
        if (i_cmd.upd) begin
            m_seq[r_slot] <= r_seq;
            m_cnt[r_slot] <= n_cnt;
            m_mis[r_slot] <= n_mis;
            r_res_status  <= ST_TRACKED;
            r_res_slot    <= slot_ext[SLOT_W-1:0];
            r_res_cnt     <= n_cnt;
            r_res_mis     <= n_mis;
        end else if (i_cmd.res_short || i_cmd.res_full) begin
            r_res_status <= i_cmd.res_short ? ST_SHORT : ST_FULL;
            r_res_slot   <= '0;
            r_res_cnt    <= '0;
            r_res_mis    <= '0;
        end
        if (i_cmd.load_out) begin
            r_out_data <= {{PAD_W{1'b0}}, r_res_mis, r_res_cnt, r_res_slot, r_res_status};
        end
    end

    assign o_out_vld  = r_out_vld;
    assign o_out_data = r_out_data;

endmodule

/* rtl/per_sender_sequence_loss_tracker.sv */
// top level of the per-sender sequence loss tracker
`timescale 1ns / 1ps

// Usage:
//   s_axis carries one received frame per transfer: source address, sequence
//   number and frame length. m_axis returns exactly one result per frame:
//   status, slot, frame count and missed total of that sender.
//   i_cfg_we / i_cfg_wdata set the minimum frame length; write only while idle.
// Timing:
//   one frame at a time. A short frame is settled in the check state, and its result
//   passes the result register into the output register. Otherwise the sender table
//   is scanned one slot per cycle through the address memory; a hit ends the scan at
//   that sender's slot, a new sender or a full table is settled at the last slot.
//   A tracked frame then passes the fetch, gap and update states. s_axis_tready
//   rises on the same edge that loads the result.
// Reset:
//   all slots free, minimum length 28, no result pending. The table needs no
//   clearing pass, the block is ready in the first cycle after reset.
// Back-pressure:
//   a finished result waits in the output register while the next frame is
//   already taken in and processed; only when a second result is ready and
//   m_axis is still stalled does the block stop taking frames.
module per_sender_sequence_loss_tracker import psslt_pkg::*; #(
    parameter int SLOTS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // src_mac[47:0], seq_num[79:48], frame_len[87:80]
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // status[1:0], slot[3:2], rx_count[35:4], missed_total[67:36], zero fill
    output logic [OUT_W-1:0] m_axis_tdata,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata
);

    t_cmd cmd;
    t_sts sts;

    psslt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_vld (s_axis_tvalid),
        .o_in_rdy (s_axis_tready),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    psslt_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (s_axis_tdata),
        .i_out_rdy   (m_axis_tready),
        .o_out_vld   (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

/* rtl/psslt_chk.sv */
// port-level checks for the loss tracker and their bind
`timescale 1ns / 1ps

module psslt_chk import psslt_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    logic [STAT_W-1:0] res_status;
    logic              untracked;

    assign res_status = m_axis_tdata[STAT_W-1:0];
    assign untracked  = (res_status == ST_SHORT) || (res_status == ST_FULL);

    // nothing pending straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // one frame at a time: no second transfer in the following cycle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken twice in a row");

    // an untracked result carries no slot or counters
    a_untracked_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && untracked) |-> (m_axis_tdata[OUT_W-1:STAT_W] == '0))
        else $error("untracked result with nonzero fields");

    // only the three defined status codes appear
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (res_status == ST_TRACKED || untracked))
        else $error("undefined status code");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind per_sender_sequence_loss_tracker psslt_chk u_psslt_chk (.*);
